// File: src/lrufr_pkg.sv
// package for the lru frame replacement core
// request codes and sizing defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrufr_pkg;

    localparam int FRAME_COUNT_DEF = 64;
    localparam int FRAME_W         = 6;
    localparam int FUNC_W          = 2;
    localparam int COUNT_W         = 7;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 16;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_INSERT = 2'd0;
    localparam t_func FUNC_TOUCH  = 2'd1;
    localparam t_func FUNC_EVICT  = 2'd2;

endpackage

`default_nettype wire

// File: src/lru_frame_replacement_core.sv
// lru frame replacement core: recency order over buffer frame numbers
// recency order in a single-port-write / registered-read memory, walked by a small sequencer
// depends on lrufr_pkg
//
// usage:
//   slave stream carries one request per transfer: tuser = func, tdata = frame number.
//   master stream returns exactly one result per request, in order.
//   insert of an untracked frame, touch of an untracked frame, evict on an empty
//   order and unused codes are handled in the idle state; the result is valid the cycle
//   after the request transfer.
//   touch, or insert of a tracked frame: the order is searched from the head until the
//   frame is found, then each later entry is shifted one position toward the head through
//   the memory read port and the frame is written at the tail.
//   evict: the head is read, then the later entries are shifted to close the gap.
//   the memory read/write pair moves one entry per cycle; that sets the rate.
//   o_s_axis_tready is high only while the sequencer is idle and the output
//   register is empty or being emptied; a stalled receiver holds the result and
//   blocks the next request.
//   reset (i_rst_n low, synchronous) empties the order and clears all tracked
//   marks at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_frame_replacement_core #(
    parameter int FRAME_COUNT = lrufr_pkg::FRAME_COUNT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [5:0] frame_num, [7:6] zero
    input  wire  [lrufr_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [1:0] func
    input  wire  [lrufr_pkg::FUNC_W-1:0]         i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // [0] victim_valid, [6:1] victim_frame, [7] was_tracked, [14:8] tracked_count, [15] zero
    output logic [lrufr_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import lrufr_pkg::*;

    localparam int DEPTH = (FRAME_COUNT < (1 << FRAME_W)) ? FRAME_COUNT : (1 << FRAME_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_HEAD   = 2'd2;
    localparam logic [1:0] ST_SHIFT  = 2'd3;

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] r_rdata;

    logic [1:0]         r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic [DEPTH-1:0]   r_mark, n_mark;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_evict, n_evict;

    logic               r_m_valid, n_m_valid;
    logic               r_vv, n_vv;
    logic [FRAME_W-1:0] r_vf, n_vf;
    logic               r_wt, n_wt;
    logic [COUNT_W-1:0] r_cnt, n_cnt;

    logic               rd_en;
    logic [LEN_W-1:0]   rd_addr;
    logic               we;
    logic [LEN_W-1:0]   wa;
    logic [FRAME_W-1:0] wd;

    logic               s_xfer;
    logic [FRAME_W-1:0] in_frame;
    t_func              in_func;
    logic               in_range;
    logic               in_tracked;
    logic [LEN_W-1:0]   idx_inc;

    assign in_frame   = i_s_axis_tdata[FRAME_W-1:0];
    assign in_func    = i_s_axis_tuser;
    assign in_range   = (32'(in_frame) < FRAME_COUNT);
    assign in_tracked = in_range && r_mark[in_frame[AW-1:0]];
    assign idx_inc    = r_idx + LEN_W'(1);

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_idx     = r_idx;
        n_mark    = r_mark;
        n_frame   = r_frame;
        n_evict   = r_evict;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_vv      = r_vv;
        n_vf      = r_vf;
        n_wt      = r_wt;
        n_cnt     = r_cnt;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        we        = 1'b0;
        wa        = r_idx;
        wd        = r_rdata;

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_frame = in_frame;
                    n_vv    = 1'b0;
                    n_vf    = '0;
                    n_wt    = 1'b0;
                    n_cnt   = COUNT_W'(r_len);
                    if ((in_func inside {FUNC_INSERT, FUNC_TOUCH}) && in_tracked) begin
                        n_evict = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = ST_SEARCH;
                    end else if (in_func == FUNC_INSERT && in_range) begin
                        we        = 1'b1;
                        wa        = r_len;
                        wd        = in_frame;
                        n_len     = r_len + LEN_W'(1);
                        n_mark[in_frame[AW-1:0]] = 1'b1;
                        n_cnt     = COUNT_W'(n_len);
                        n_m_valid = 1'b1;
                    end else if (in_func == FUNC_EVICT && r_len != '0) begin
                        n_evict = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = ST_HEAD;
                    end else begin
                        n_m_valid = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                rd_en   = 1'b1;
                rd_addr = idx_inc;
                n_idx   = idx_inc;
                if (r_rdata == r_frame) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_HEAD: begin
                n_vv    = 1'b1;
                n_vf    = r_rdata;
                n_mark[r_rdata[AW-1:0]] = 1'b0;
                rd_en   = 1'b1;
                rd_addr = LEN_W'(1);
                n_idx   = LEN_W'(1);
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_idx < r_len) begin
                    we      = 1'b1;
                    wa      = r_idx - LEN_W'(1);
                    wd      = r_rdata;
                    rd_en   = 1'b1;
                    rd_addr = idx_inc;
                    n_idx   = idx_inc;
                end else begin
                    if (r_evict) begin
                        n_len = r_len - LEN_W'(1);
                    end else begin
                        we   = 1'b1;
                        wa   = r_len - LEN_W'(1);
                        wd   = r_frame;
                        n_wt = 1'b1;
                    end
                    n_cnt     = COUNT_W'(n_len);
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // recency order storage, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa[AW-1:0]] <= wd;
        end
        if (rd_en && (32'(rd_addr) < DEPTH)) begin
            r_rdata <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_mark    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_mark    <= n_mark;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_frame <= n_frame;
        r_evict <= n_evict;
        r_vv    <= n_vv;
        r_vf    <= n_vf;
        r_wt    <= n_wt;
        r_cnt   <= n_cnt;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_cnt, r_wt, r_vf, r_vv};

endmodule

`default_nettype wire
